// ===== rtl/nsg_pkg.sv =====
// Shared types, sentence templates and small arithmetic helpers for the NMEA sentence generator.
package nsg_pkg;

    localparam int BODY_MAX = 42;

    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] TYPE_MAX = 3'd4;
    localparam logic [2:0] TYPE_POS = 3'd0;
    localparam logic [2:0] TYPE_HDG = 3'd1;
    localparam logic [2:0] TYPE_DEP = 3'd2;
    localparam logic [2:0] TYPE_SPD = 3'd3;

    localparam logic [13:0] MAG_MAX = 14'd9999;
    localparam logic [4:0]  HH_MAX  = 5'd23;
    localparam logic [5:0]  MS_MAX  = 6'd59;
    localparam logic [6:0]  CC_MAX  = 7'd99;

    localparam logic [8*42-1:0] STR_GLL = "GPGLL,4542.5020,N,02817.1540,E,192141.99,A";
    localparam logic [8*13-1:0] STR_HDT = "HCHDT,354.0,T";
    localparam logic [8*16-1:0] STR_DBT = "SDDBT,,,10.0,M,,";
    localparam logic [8*18-1:0] STR_VBW = "VMVBW,,,,,10.0,N,,";
    localparam logic [8*14-1:0] STR_RSA = "RCRSA,00.0,A,,";
    localparam logic [8*15-1:0] STR_RSN = "RCRSA,-00.1,A,,";

    typedef enum logic [2:0] {
        TPL_GLL,
        TPL_HDT,
        TPL_DBT,
        TPL_VBW,
        TPL_RSA,
        TPL_RSN
    } tpl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic conv;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic type_ok;
        logic conv_done;
        logic room;
        logic at_end;
    } sts_t;

    function automatic logic [5:0] tpl_len(tpl_t t);
        logic [5:0] n;
        case (t)
            TPL_GLL: n = 6'd42;
            TPL_HDT: n = 6'd13;
            TPL_DBT: n = 6'd16;
            TPL_VBW: n = 6'd18;
            TPL_RSA: n = 6'd14;
            TPL_RSN: n = 6'd15;
            default: n = 6'd0;
        endcase
        return n;
    endfunction

    // Templates are right-justified in their constants, so a character sits
    // at an offset counted back from the template's end.
    function automatic logic [7:0] tpl_char(tpl_t t, logic [5:0] pos);
        logic [7:0] ch;
        int         sh;
        ch = CH_SPACE;
        sh = 8 * (int'(tpl_len(t)) - 1 - int'(pos));
        if (pos < tpl_len(t))
        begin
            case (t)
                TPL_GLL: ch = STR_GLL[sh +: 8];
                TPL_HDT: ch = STR_HDT[sh +: 8];
                TPL_DBT: ch = STR_DBT[sh +: 8];
                TPL_VBW: ch = STR_VBW[sh +: 8];
                TPL_RSA: ch = STR_RSA[sh +: 8];
                TPL_RSN: ch = STR_RSN[sh +: 8];
                default: ch = CH_SPACE;
            endcase
        end
        return ch;
    endfunction

    // Tens digit of a value below 100 by multiplying with 205/2048.
    function automatic logic [3:0] tens_of(logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] units_of(logic [6:0] v);
        logic [3:0] t;
        logic [6:0] r;
        t = tens_of(v);
        r = v - ({t, 3'b000} + {2'b00, t, 1'b0});
        return r[3:0];
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        logic [7:0] ch;
        if (n < 4'd10)
        begin
            ch = CH_ZERO + {4'd0, n};
        end
        else
        begin
            ch = 8'h37 + {4'd0, n};
        end
        return ch;
    endfunction

endpackage

// ===== rtl/nsg_ctrl.sv =====
// Controller state machine: request intake, digit conversion and byte emission sequencing.
module nsg_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  nsg_pkg::sts_t sts,
    output nsg_pkg::cmd_t cmd
);
    import nsg_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && sts.type_ok)
                begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.room && sts.at_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        req_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid && sts.type_ok;
            end
            ST_CONV:
            begin
                cmd.conv = !sts.conv_done;
            end
            ST_EMIT:
            begin
                cmd.emit = sts.room;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/nsg_datapath.sv =====
// Datapath: request capture, decimal conversion, sentence byte selection, checksum and output register.
module nsg_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  nsg_pkg::cmd_t      cmd,
    output nsg_pkg::sts_t      sts,
    input  logic [2:0]         sentence_type,
    input  logic signed [14:0] value,
    input  logic [4:0]         hours,
    input  logic [5:0]         minutes,
    input  logic [5:0]         seconds,
    input  logic [6:0]         hundredths,
    input  logic               rsp_stall,
    output logic               rsp_valid,
    output logic [7:0]         out_byte,
    output logic               last_byte
);
    import nsg_pkg::*;

    tpl_t        tpl_reg;
    logic [13:0] rem_reg;
    logic [1:0]  dsel_reg;
    logic [3:0]  dig_reg [3];
    logic [3:0]  time_reg [8];
    logic [5:0]  idx_reg;
    logic [7:0]  sum_reg;
    logic        rsp_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;

    logic        neg;
    logic [14:0] mag_full;
    logic [13:0] mag;
    logic [6:0]  hh_sat;
    logic [6:0]  mm_sat;
    logic [6:0]  ss_sat;
    logic [6:0]  cc_sat;
    logic [13:0] weight;
    logic [5:0]  len;
    logic [5:0]  pos;
    logic [3:0]  dsub;
    logic        dsub_hit;
    logic [7:0]  body_char;
    logic [7:0]  cur_byte;
    logic        in_body;
    tpl_t        tpl_sel;

    assign neg      = value[14];
    assign mag_full = neg ? (15'd0 - value) : value;
    assign mag      = (mag_full > {1'b0, MAG_MAX}) ? MAG_MAX : mag_full[13:0];
    assign hh_sat   = {2'b00, (hours > HH_MAX) ? HH_MAX : hours};
    assign mm_sat   = {1'b0, (minutes > MS_MAX) ? MS_MAX : minutes};
    assign ss_sat   = {1'b0, (seconds > MS_MAX) ? MS_MAX : seconds};
    assign cc_sat   = (hundredths > CC_MAX) ? CC_MAX : hundredths;

    always_comb
    begin
        case (sentence_type)
            TYPE_POS: tpl_sel = TPL_GLL;
            TYPE_HDG: tpl_sel = TPL_HDT;
            TYPE_DEP: tpl_sel = TPL_DBT;
            TYPE_SPD: tpl_sel = TPL_VBW;
            default:  tpl_sel = neg ? TPL_RSN : TPL_RSA;
        endcase
    end

    always_comb
    begin
        case (dsel_reg)
            2'd0:    weight = 14'd1000;
            2'd1:    weight = 14'd100;
            default: weight = 14'd10;
        endcase
    end

    // Conversion by repeated subtraction, one decimal weight after another.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            tpl_reg     <= tpl_sel;
            rem_reg     <= mag;
            dig_reg[0]  <= 4'd0;
            dig_reg[1]  <= 4'd0;
            dig_reg[2]  <= 4'd0;
            time_reg[0] <= tens_of(hh_sat);
            time_reg[1] <= units_of(hh_sat);
            time_reg[2] <= tens_of(mm_sat);
            time_reg[3] <= units_of(mm_sat);
            time_reg[4] <= tens_of(ss_sat);
            time_reg[5] <= units_of(ss_sat);
            time_reg[6] <= tens_of(cc_sat);
            time_reg[7] <= units_of(cc_sat);
        end
        else if (cmd.conv && (rem_reg >= weight))
        begin
            rem_reg           <= rem_reg - weight;
            dig_reg[dsel_reg] <= dig_reg[dsel_reg] + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dsel_reg      <= 2'd0;
            idx_reg       <= 6'd0;
            sum_reg       <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                dsel_reg <= 2'd0;
                idx_reg  <= 6'd0;
                sum_reg  <= 8'd0;
            end
            else
            begin
                if (cmd.conv && (rem_reg < weight))
                begin
                    dsel_reg <= dsel_reg + 2'd1;
                end
                if (cmd.emit)
                begin
                    idx_reg <= idx_reg + 6'd1;
                    if (in_body)
                    begin
                        sum_reg <= sum_reg ^ cur_byte;
                    end
                end
            end
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= sts.at_end;
        end
    end

    assign len     = tpl_len(tpl_reg);
    assign pos     = idx_reg - 6'd1;
    assign in_body = (idx_reg != 6'd0) && (idx_reg <= len);

    // Digits that replace template characters at fixed body positions.
    always_comb
    begin
        dsub     = 4'd0;
        dsub_hit = 1'b1;
        case (tpl_reg)
            TPL_GLL:
            begin
                case (pos)
                    6'd24:   dsub = dig_reg[0];
                    6'd25:   dsub = dig_reg[1];
                    6'd26:   dsub = dig_reg[2];
                    6'd27:   dsub = rem_reg[3:0];
                    6'd31:   dsub = time_reg[0];
                    6'd32:   dsub = time_reg[1];
                    6'd33:   dsub = time_reg[2];
                    6'd34:   dsub = time_reg[3];
                    6'd35:   dsub = time_reg[4];
                    6'd36:   dsub = time_reg[5];
                    6'd38:   dsub = time_reg[6];
                    6'd39:   dsub = time_reg[7];
                    default: dsub_hit = 1'b0;
                endcase
            end
            TPL_HDT:
            begin
                case (pos)
                    6'd6:    dsub = dig_reg[0];
                    6'd7:    dsub = dig_reg[1];
                    6'd8:    dsub = dig_reg[2];
                    6'd10:   dsub = rem_reg[3:0];
                    default: dsub_hit = 1'b0;
                endcase
            end
            TPL_DBT:
            begin
                case (pos)
                    6'd8:    dsub = dig_reg[1];
                    6'd9:    dsub = dig_reg[2];
                    6'd11:   dsub = rem_reg[3:0];
                    default: dsub_hit = 1'b0;
                endcase
            end
            TPL_VBW:
            begin
                case (pos)
                    6'd10:   dsub = dig_reg[1];
                    6'd11:   dsub = dig_reg[2];
                    6'd13:   dsub = rem_reg[3:0];
                    default: dsub_hit = 1'b0;
                endcase
            end
            TPL_RSA:
            begin
                case (pos)
                    6'd6:    dsub = dig_reg[1];
                    6'd7:    dsub = dig_reg[2];
                    6'd9:    dsub = rem_reg[3:0];
                    default: dsub_hit = 1'b0;
                endcase
            end
            TPL_RSN:
            begin
                case (pos)
                    6'd7:    dsub = dig_reg[1];
                    6'd8:    dsub = dig_reg[2];
                    6'd10:   dsub = rem_reg[3:0];
                    default: dsub_hit = 1'b0;
                endcase
            end
            default:
            begin
                dsub_hit = 1'b0;
            end
        endcase
    end

    assign body_char = dsub_hit ? (CH_ZERO + {4'd0, dsub}) : tpl_char(tpl_reg, pos);

    always_comb
    begin
        if (idx_reg == 6'd0)
        begin
            cur_byte = CH_DOLLAR;
        end
        else if (in_body)
        begin
            cur_byte = body_char;
        end
        else if (idx_reg == len + 6'd1)
        begin
            cur_byte = CH_STAR;
        end
        else if (idx_reg == len + 6'd2)
        begin
            cur_byte = hex_char(sum_reg[7:4]);
        end
        else if (idx_reg == len + 6'd3)
        begin
            cur_byte = hex_char(sum_reg[3:0]);
        end
        else if (idx_reg == len + 6'd4)
        begin
            cur_byte = CH_CR;
        end
        else
        begin
            cur_byte = CH_LF;
        end
    end

    assign sts.type_ok   = (sentence_type <= TYPE_MAX);
    assign sts.conv_done = (dsel_reg == 2'd3);
    assign sts.room      = !rsp_valid_reg || !rsp_stall;
    assign sts.at_end    = (idx_reg == len + 6'd5);

    assign rsp_valid = rsp_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_reg;

endmodule

// ===== rtl/nmea_sentence_generator.sv =====
// Top level of the NMEA 0183 sentence generator.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+------------------------------------------------
//   request | req_valid / req_stall | sentence_type, value, hours, minutes, seconds,
//           |                       | hundredths
//   bytes   | rsp_valid / rsp_stall | out_byte, last_byte
//
// A request is taken in one transfer, then converted to decimal (repeated subtraction
// of 1000, 100 and 10, one step a cycle, then a turnaround in ST_CONV) and emitted at
// one byte per cycle while the byte channel does not stall, 19 to 48 bytes. Sentence
// types above 4 are taken and produce nothing. Reset clears the controller and the
// output valid. A stall on the byte channel holds the current byte and pauses emission;
// req_stall stays high from a transfer until the sentence's last byte is loaded.
module nmea_sentence_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [2:0]         sentence_type,
    input  logic signed [14:0] value,
    input  logic [4:0]         hours,
    input  logic [5:0]         minutes,
    input  logic [5:0]         seconds,
    input  logic [6:0]         hundredths,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [7:0]         out_byte,
    output logic               last_byte
);
    import nsg_pkg::*;

    cmd_t cmd;
    sts_t sts;

    nsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    nsg_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .sentence_type (sentence_type),
        .value         (value),
        .hours         (hours),
        .minutes       (minutes),
        .seconds       (seconds),
        .hundredths    (hundredths),
        .rsp_stall     (rsp_stall),
        .rsp_valid     (rsp_valid),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

endmodule

// ===== rtl/nsg_checker.sv =====
// Port-level checker for the NMEA sentence generator and its bind statement.
module nsg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic [2:0]         sentence_type,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [7:0]         out_byte,
    input logic               last_byte
);
    import nsg_pkg::*;

    // A stalled byte stays offered and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_byte) && $stable(last_byte))
        else $error("stalled output byte changed");

    // The last-byte flag marks the line feed and nothing else.
    a_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (last_byte == (out_byte == CH_LF)))
        else $error("last_byte does not match the line feed");

    // A taken request of a known type makes the block busy (req_stall high).
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && (sentence_type <= TYPE_MAX) |=> req_stall)
        else $error("request transfer did not start a sentence");

    // When the block takes requests, no unfinished sentence is pending.
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !req_stall && rsp_valid |-> last_byte)
        else $error("ready for a request in the middle of a sentence");

endmodule

bind nmea_sentence_generator nsg_checker u_nsg_checker (.*);
